FILE: rtl/rbcr_pkg.sv
// Shared types, codes and the CRC-8 step for the RS485 bus client responder.
package rbcr_pkg;

    typedef enum logic [1:0] {
        MODE_RX       = 2'd0,
        MODE_SETPOINT = 2'd1,
        MODE_TIME     = 2'd2,
        MODE_TOGGLE   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  rx_byte;
        logic [7:0]  setpoint_half_deg;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [1:0]  toggle_select;
    } t_item;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_last;
    } t_result;

    localparam int BODY_MAX = 6;

    // One reply frame waiting to be serialized: body bytes, body[0] goes first.
    typedef struct packed {
        logic [2:0]                 body_len;
        logic [BODY_MAX-1:0][7:0]   body;
    } t_reply;

    localparam int REPLY_QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] FLAG        = 8'h7E;
    localparam logic [5:0] MAX_ID      = 6'h2F;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_INIT    = 8'h02;
    localparam logic [7:0] CRC_XOROUT  = 8'h02;
    localparam logic [7:0] CLIENT_TAG  = 8'hBF;

    localparam logic [7:0] ADDR_NEW    = 8'hFE;
    localparam logic [7:0] ADDR_BCAST  = 8'hFF;

    localparam logic [7:0] TYPE_POLL      = 8'h00;
    localparam logic [7:0] TYPE_ID_OFFER  = 8'h02;
    localparam logic [7:0] TYPE_ID_ACK    = 8'h03;
    localparam logic [7:0] TYPE_CTS       = 8'h06;
    localparam logic [7:0] TYPE_NOTHING   = 8'h07;
    localparam logic [7:0] TYPE_STATUS    = 8'h13;
    localparam logic [7:0] TYPE_SETTEMP   = 8'h20;
    localparam logic [7:0] TYPE_SETTIME   = 8'h21;
    localparam logic [7:0] TYPE_SETTINGS  = 8'h22;
    localparam logic [7:0] TYPE_FILTER    = 8'h23;
    localparam logic [7:0] TYPE_FAULT     = 8'h28;
    localparam logic [7:0] TYPE_CONFIG    = 8'h2E;
    localparam logic [7:0] TYPE_TOGGLE    = 8'h11;

    localparam logic [7:0] CMD_NONE     = 8'h00;
    localparam logic [7:0] CMD_SETTIME  = 8'h21;
    localparam logic [7:0] CMD_SETPOINT = 8'hFF;
    localparam logic [7:0] CMD_LIGHT    = 8'h11;
    localparam logic [7:0] CMD_JET1     = 8'h04;
    localparam logic [7:0] CMD_JET2     = 8'h05;

    localparam logic [1:0] SEL_LIGHT = 2'd0;
    localparam logic [1:0] SEL_JET1  = 2'd1;
    localparam logic [1:0] SEL_JET2  = 2'd2;

    localparam logic [1:0] STAGE_WANTED    = 2'd0;
    localparam logic [1:0] STAGE_REQUESTED = 2'd1;
    localparam logic [1:0] STAGE_RECEIVED  = 2'd2;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/rbcr_front.sv
// Front end: frame assembly, host commands, node state and reply selection.
module rbcr_front
    import rbcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_item   i_item,
    output logic    o_reply_valid,
    output t_reply  o_reply
);

    logic [7:0] r_count, n_count;
    logic       r_past_end, n_past_end;
    logic [7:0] r_len, n_len;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_type, n_type;
    logic [7:0] r_pf, n_pf;
    logic [7:0] r_hour_b, n_hour_b;
    logic [7:0] r_min_b, n_min_b;
    logic [7:0] r_check, n_check;
    logic [5:0] r_node_id, n_node_id;
    logic [7:0] r_pend_cmd, n_pend_cmd;
    logic [7:0] r_pend_sp, n_pend_sp;
    logic [4:0] r_pend_hour, n_pend_hour;
    logic [5:0] r_pend_min, n_pend_min;
    logic [1:0] r_cfg_stage, n_cfg_stage;
    logic [1:0] r_flt_stage, n_flt_stage;
    logic [1:0] r_fil_stage, n_fil_stage;
    logic [7:0] r_last_check, n_last_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_past_end   <= 1'b0;
            r_len        <= '0;
            r_addr       <= '0;
            r_type       <= '0;
            r_pf         <= '0;
            r_hour_b     <= '0;
            r_min_b      <= '0;
            r_check      <= '0;
            r_node_id    <= '0;
            r_pend_cmd   <= CMD_NONE;
            r_pend_sp    <= '0;
            r_pend_hour  <= '0;
            r_pend_min   <= '0;
            r_cfg_stage  <= STAGE_WANTED;
            r_flt_stage  <= STAGE_WANTED;
            r_fil_stage  <= STAGE_WANTED;
            r_last_check <= '0;
        end else begin
            r_count      <= n_count;
            r_past_end   <= n_past_end;
            r_len        <= n_len;
            r_addr       <= n_addr;
            r_type       <= n_type;
            r_pf         <= n_pf;
            r_hour_b     <= n_hour_b;
            r_min_b      <= n_min_b;
            r_check      <= n_check;
            r_node_id    <= n_node_id;
            r_pend_cmd   <= n_pend_cmd;
            r_pend_sp    <= n_pend_sp;
            r_pend_hour  <= n_pend_hour;
            r_pend_min   <= n_pend_min;
            r_cfg_stage  <= n_cfg_stage;
            r_flt_stage  <= n_flt_stage;
            r_fil_stage  <= n_fil_stage;
            r_last_check <= n_last_check;
        end
    end

    always_comb begin
        logic [7:0] x;
        logic       fresh;
        logic       to_me;
        logic [5:0] id;
        x             = i_item.rx_byte;
        fresh         = 1'b0;
        to_me         = 1'b0;
        id            = '0;
        n_count       = r_count;
        n_past_end    = r_past_end;
        n_len         = r_len;
        n_addr        = r_addr;
        n_type        = r_type;
        n_pf          = r_pf;
        n_hour_b      = r_hour_b;
        n_min_b       = r_min_b;
        n_check       = r_check;
        n_node_id     = r_node_id;
        n_pend_cmd    = r_pend_cmd;
        n_pend_sp     = r_pend_sp;
        n_pend_hour   = r_pend_hour;
        n_pend_min    = r_pend_min;
        n_cfg_stage   = r_cfg_stage;
        n_flt_stage   = r_flt_stage;
        n_fil_stage   = r_fil_stage;
        n_last_check  = r_last_check;
        o_reply_valid = 1'b0;
        o_reply       = '0;

        if (i_accept) begin
            unique case (i_item.mode)
                MODE_SETPOINT: begin
                    n_pend_sp  = i_item.setpoint_half_deg;
                    n_pend_cmd = CMD_SETPOINT;
                end
                MODE_TIME: begin
                    if (i_item.clock_hour <= HOUR_MAX && i_item.clock_minute <= MINUTE_MAX) begin
                        n_pend_hour = i_item.clock_hour;
                        n_pend_min  = i_item.clock_minute;
                        n_pend_cmd  = CMD_SETTIME;
                    end
                end
                MODE_TOGGLE: begin
                    priority case (i_item.toggle_select)
                        SEL_LIGHT: n_pend_cmd = CMD_LIGHT;
                        SEL_JET1:  n_pend_cmd = CMD_JET1;
                        SEL_JET2:  n_pend_cmd = CMD_JET2;
                        default:   n_pend_cmd = r_pend_cmd;
                    endcase
                end
                MODE_RX: begin
                    if (r_count == 8'd0) begin
                        if (x == FLAG) begin
                            n_count    = 8'd1;
                            n_past_end = 1'b0;
                            n_len      = '0;
                            n_addr     = '0;
                            n_type     = '0;
                            n_pf       = '0;
                            n_hour_b   = '0;
                            n_min_b    = '0;
                            n_check    = '0;
                        end
                    end else if (!(r_count == 8'd1 && x == FLAG)) begin
                        if (!r_past_end) begin
                            if (r_count == 8'd1) begin
                                n_len = x;
                                // length 0 points at the start flag, 1 at the length byte
                                n_check = (x == 8'd0) ? FLAG : ((x == 8'd1) ? x : 8'd0);
                            end else begin
                                if (r_count == 8'd2) n_addr = x;
                                if (r_count == 8'd4) n_type = x;
                                if (r_count == 8'd5) n_pf = x;
                                if (r_count == 8'd8) n_hour_b = x;
                                if (r_count == 8'd9) n_min_b = x;
                                if (r_count == r_len) n_check = x;
                            end
                        end
                        if (r_count != 8'hFF) n_count = r_count + 8'd1;
                        else n_past_end = 1'b1;

                        if (x == FLAG) begin
                            n_count    = 8'd0;
                            n_past_end = 1'b0;
                            fresh      = (r_last_check != n_check);
                            to_me      = (n_addr == {2'b00, r_node_id});
                            if (r_node_id == 6'd0) begin
                                if (n_addr == ADDR_NEW && n_type == TYPE_ID_OFFER) begin
                                    id = (n_pf > {2'b00, MAX_ID}) ? MAX_ID : n_pf[5:0];
                                    n_node_id       = id;
                                    o_reply_valid   = 1'b1;
                                    o_reply.body_len = 3'd3;
                                    o_reply.body[0] = {2'b00, id};
                                    o_reply.body[1] = CLIENT_TAG;
                                    o_reply.body[2] = TYPE_ID_ACK;
                                end else if (n_addr == ADDR_NEW && n_type == TYPE_POLL) begin
                                    o_reply_valid   = 1'b1;
                                    o_reply.body_len = 3'd6;
                                    o_reply.body[0] = ADDR_NEW;
                                    o_reply.body[1] = CLIENT_TAG;
                                    o_reply.body[2] = 8'h01;
                                    o_reply.body[3] = 8'h02;
                                    o_reply.body[4] = 8'hF1;
                                    o_reply.body[5] = 8'h73;
                                end
                            end else if (to_me && n_type == TYPE_CTS) begin
                                o_reply_valid   = 1'b1;
                                o_reply.body[0] = {2'b00, r_node_id};
                                o_reply.body[1] = CLIENT_TAG;
                                n_pend_cmd      = CMD_NONE;
                                priority if (r_pend_cmd == CMD_SETTIME) begin
                                    o_reply.body_len = 3'd5;
                                    o_reply.body[2]  = TYPE_SETTIME;
                                    o_reply.body[3]  = {3'b000, r_pend_hour};
                                    o_reply.body[4]  = {2'b00, r_pend_min};
                                end else if (r_pend_cmd == CMD_SETPOINT) begin
                                    o_reply.body_len = 3'd4;
                                    o_reply.body[2]  = TYPE_SETTEMP;
                                    o_reply.body[3]  = r_pend_sp;
                                end else if (r_pend_cmd == CMD_NONE) begin
                                    // idle poll: walk through the info requests in order
                                    priority if (r_cfg_stage == STAGE_WANTED) begin
                                        o_reply.body_len = 3'd6;
                                        o_reply.body[2]  = TYPE_SETTINGS;
                                        o_reply.body[5]  = 8'h01;
                                        n_cfg_stage      = STAGE_REQUESTED;
                                    end else if (r_flt_stage == STAGE_WANTED) begin
                                        o_reply.body_len = 3'd6;
                                        o_reply.body[2]  = TYPE_SETTINGS;
                                        o_reply.body[3]  = 8'h20;
                                        o_reply.body[4]  = 8'hFF;
                                        n_flt_stage      = STAGE_REQUESTED;
                                    end else if (r_fil_stage == STAGE_WANTED &&
                                                 r_flt_stage == STAGE_RECEIVED) begin
                                        o_reply.body_len = 3'd6;
                                        o_reply.body[2]  = TYPE_SETTINGS;
                                        o_reply.body[3]  = 8'h01;
                                        n_fil_stage      = STAGE_REQUESTED;
                                    end else begin
                                        o_reply.body_len = 3'd3;
                                        o_reply.body[2]  = TYPE_NOTHING;
                                    end
                                end else begin
                                    o_reply.body_len = 3'd5;
                                    o_reply.body[2]  = TYPE_TOGGLE;
                                    o_reply.body[3]  = r_pend_cmd;
                                end
                            end else if (to_me && n_type == TYPE_CONFIG) begin
                                if (fresh) n_cfg_stage = STAGE_RECEIVED;
                            end else if (to_me && n_type == TYPE_FAULT) begin
                                if (fresh) n_flt_stage = STAGE_RECEIVED;
                            end else if (n_addr == ADDR_BCAST && n_type == TYPE_STATUS) begin
                                if (fresh) begin
                                    n_pend_hour  = n_hour_b[4:0];
                                    n_pend_min   = n_min_b[5:0];
                                    n_last_check = n_check;
                                end
                            end else if (to_me && n_type == TYPE_FILTER) begin
                                if (fresh) n_fil_stage = STAGE_RECEIVED;
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/rbcr_fifo.sv
// Small register queue of reply requests between front and back ends.
module rbcr_fifo
    import rbcr_pkg::*;
#(
    parameter int WIDTH = $bits(t_reply),
    parameter int DEPTH = REPLY_QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_rd,
    output logic [WIDTH-1:0]  o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_fire, rd_fire;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_fire = i_wr && !o_full;
    assign rd_fire = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_fire) n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        if (rd_fire) n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        if (wr_fire && !rd_fire) n_cnt = r_cnt + 1'b1;
        else if (rd_fire && !wr_fire) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

FILE: rtl/rbcr_back.sv
// Back end: serializes one reply into flagged, length-prefixed, CRC-8 bytes.
module rbcr_back
    import rbcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_have_reply,
    input  t_reply  i_reply,
    output logic    o_reply_done,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic [3:0] r_idx, n_idx;
    logic [7:0] r_crc, n_crc;
    logic       r_valid, n_valid;
    t_result    r_out, n_out;

    logic       load;
    logic [3:0] body_end;
    logic [3:0] bidx;
    logic [7:0] len_byte;

    assign o_empty  = !r_valid;
    assign o_result = r_out;
    assign load     = i_have_reply && (!r_valid || i_pop);
    assign body_end = {1'b0, i_reply.body_len} + 4'd1;
    assign bidx     = r_idx - 4'd2;
    assign len_byte = {5'b00000, i_reply.body_len} + 8'd2;

    always_comb begin
        n_idx        = r_idx;
        n_crc        = r_crc;
        n_valid      = r_valid && !i_pop;
        n_out        = r_out;
        o_reply_done = 1'b0;
        if (load) begin
            n_valid       = 1'b1;
            n_out.tx_last = 1'b0;
            n_idx         = r_idx + 4'd1;
            priority if (r_idx == 4'd0) begin
                n_out.tx_byte = FLAG;
            end else if (r_idx == 4'd1) begin
                n_out.tx_byte = len_byte;
                n_crc         = crc_step(CRC_INIT, len_byte);
            end else if (r_idx <= body_end) begin
                n_out.tx_byte = i_reply.body[bidx[2:0]];
                n_crc         = crc_step(r_crc, i_reply.body[bidx[2:0]]);
            end else if (r_idx == body_end + 4'd1) begin
                n_out.tx_byte = r_crc ^ CRC_XOROUT;
            end else begin
                n_out.tx_byte = FLAG;
                n_out.tx_last = 1'b1;
                n_idx         = '0;
                o_reply_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_out <= n_out;
    end

endmodule

FILE: rtl/rs485_bus_client_responder_unit.sv
// Top level of the RS485 bus client responder.
//
// Every input request (bus byte or host command) is taken by the front end
// while the reply queue is not full; the front end assembles frames and
// updates node state, and a frame that needs an answer leaves a reply request
// in a REPLY_QUEUE_DEPTH-deep queue. The back end turns each reply into 7 to
// 10 result bytes, one per cycle while pop is high, through a registered
// output stage. The first byte of a reply is loaded into that stage once the
// reply heads the queue and the stage is empty or being popped. With pop held
// high the next queued reply follows with no gap. A reply keeps its queue
// entry until its last byte is loaded; full rises only while the queue is full.
module rs485_bus_client_responder_unit
    import rbcr_pkg::*;
#(
    parameter int REPLY_QUEUE_DEPTH = REPLY_QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic   accept;
    logic   reply_valid;
    t_reply reply_in;
    t_reply reply_head;
    logic   q_full;
    logic   q_empty;
    logic   reply_done;

    assign full   = q_full;
    assign accept = push && !q_full;

    rbcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .o_reply_valid (reply_valid),
        .o_reply       (reply_in)
    );

    rbcr_fifo #(
        .WIDTH ($bits(t_reply)),
        .DEPTH (REPLY_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (reply_valid),
        .i_data  (reply_in),
        .i_rd    (reply_done),
        .o_data  (reply_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rbcr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_have_reply (!q_empty),
        .i_reply      (reply_head),
        .o_reply_done (reply_done),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

FILE: test/rs485_bus_client_responder_unit_tb.sv
// Testbench for the RS485 bus client responder: bus frames and host commands in, reply bytes out.
`timescale 1ns / 1ps

module rs485_bus_client_responder_unit_tb;
    import rbcr_pkg::*;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   item_in;
    logic    empty;
    logic    pop = 1'b0;
    t_result result_out;

    rs485_bus_client_responder_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item_in),
        .empty    (empty),
        .pop      (pop),
        .o_result (result_out)
    );

    // expected reply bytes, oldest first
    t_result reply_bytes_due[$];

    int send_idle_pct = 35;
    int recv_idle_pct = 81;
    int requests_sent = 0;
    int frames_due    = 0;
    int bytes_checked = 0;
    int errors        = 0;

    // client state as the bus should see it
    logic [7:0] fr_count, fr_len, fr_addr, fr_type, fr_pay, fr_hour, fr_min, fr_chk;
    bit         fr_past;
    logic [7:0] my_id, pend_cmd, pend_sp, pend_hr, pend_mn, last_chk;
    logic [1:0] cfg_st, flt_st, fil_st;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_07(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            r = {r[6:0], 1'b0} ^ ((r[7] ^ d[i]) ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void queue_byte(input logic [7:0] v, input logic is_last);
        t_result r;
        r.tx_byte = v;
        r.tx_last = is_last;
        reply_bytes_due.insert(reply_bytes_due.size(), r);
    endfunction

    function automatic void push_reply(input logic [7:0] b [0:5], input int n);
        logic [7:0] len;
        logic [7:0] crc;
        len = 8'(n + 2);
        crc = crc8_07(CRC_INIT, len);
        for (int k = 0; k < n; k++) crc = crc8_07(crc, b[k]);
        crc = crc ^ CRC_XOROUT;
        queue_byte(FLAG, 1'b0);
        queue_byte(len, 1'b0);
        for (int k = 0; k < n; k++) queue_byte(b[k], 1'b0);
        queue_byte(crc, 1'b0);
        queue_byte(FLAG, 1'b1);
        frames_due++;
    endfunction

    function automatic void clear_client_state();
        fr_count = '0; fr_len = '0; fr_addr = '0; fr_type = '0;
        fr_pay = '0; fr_hour = '0; fr_min = '0; fr_chk = '0;
        fr_past = 1'b0;
        my_id = '0; pend_cmd = CMD_NONE; pend_sp = '0; pend_hr = '0; pend_mn = '0;
        last_chk = '0;
        cfg_st = STAGE_WANTED; flt_st = STAGE_WANTED; fil_st = STAGE_WANTED;
    endfunction

    function automatic void capture_byte(input logic [7:0] idx, input logic [7:0] x);
        if (idx == 8'd1) begin
            fr_len = x;
            // check position may be the start flag or the length byte itself
            fr_chk = (x == 8'd0) ? FLAG : ((x == 8'd1) ? x : 8'h00);
            return;
        end
        if (idx == 8'd2) fr_addr = x;
        if (idx == 8'd4) fr_type = x;
        if (idx == 8'd5) fr_pay  = x;
        if (idx == 8'd8) fr_hour = x;
        if (idx == 8'd9) fr_min  = x;
        if (idx >= 8'd2 && idx == fr_len) fr_chk = x;
    endfunction

    function automatic void frame_done();
        logic [7:0] b [0:5];
        int         n;
        bit         fresh;
        logic [7:0] id;
        n = 0;
        fresh = (last_chk != fr_chk);
        if (my_id == 8'd0) begin
            if (fr_addr == ADDR_NEW && fr_type == TYPE_ID_OFFER) begin
                id = (fr_pay > {2'b00, MAX_ID}) ? {2'b00, MAX_ID} : fr_pay;
                my_id = id;
                b[0] = id; b[1] = CLIENT_TAG; b[2] = TYPE_ID_ACK;
                push_reply(b, 3);
            end else if (fr_addr == ADDR_NEW && fr_type == TYPE_POLL) begin
                b[0] = ADDR_NEW; b[1] = CLIENT_TAG; b[2] = 8'h01;
                b[3] = 8'h02; b[4] = 8'hF1; b[5] = 8'h73;
                push_reply(b, 6);
            end
            return;
        end
        if (fr_addr == my_id && fr_type == TYPE_CTS) begin
            b[0] = my_id; b[1] = CLIENT_TAG;
            if (pend_cmd == CMD_SETTIME) begin
                b[2] = TYPE_SETTIME; b[3] = pend_hr; b[4] = pend_mn; n = 5;
            end else if (pend_cmd == CMD_SETPOINT) begin
                b[2] = TYPE_SETTEMP; b[3] = pend_sp; n = 4;
            end else if (pend_cmd == CMD_NONE) begin
                if (cfg_st == STAGE_WANTED) begin
                    b[2] = TYPE_SETTINGS; b[3] = 8'h00; b[4] = 8'h00; b[5] = 8'h01; n = 6;
                    cfg_st = STAGE_REQUESTED;
                end else if (flt_st == STAGE_WANTED) begin
                    b[2] = TYPE_SETTINGS; b[3] = 8'h20; b[4] = 8'hFF; b[5] = 8'h00; n = 6;
                    flt_st = STAGE_REQUESTED;
                end else if (fil_st == STAGE_WANTED && flt_st == STAGE_RECEIVED) begin
                    b[2] = TYPE_SETTINGS; b[3] = 8'h01; b[4] = 8'h00; b[5] = 8'h00; n = 6;
                    fil_st = STAGE_REQUESTED;
                end else begin
                    b[2] = TYPE_NOTHING; n = 3;
                end
            end else begin
                b[2] = TYPE_TOGGLE; b[3] = pend_cmd; b[4] = 8'h00; n = 5;
            end
            pend_cmd = CMD_NONE;
            push_reply(b, n);
            return;
        end
        if (fr_addr == my_id && fr_type == TYPE_CONFIG) begin
            if (fresh) cfg_st = STAGE_RECEIVED;
        end else if (fr_addr == my_id && fr_type == TYPE_FAULT) begin
            if (fresh) flt_st = STAGE_RECEIVED;
        end else if (fr_addr == ADDR_BCAST && fr_type == TYPE_STATUS) begin
            if (fresh) begin
                pend_hr  = {3'b000, fr_hour[4:0]};
                pend_mn  = {2'b00, fr_min[5:0]};
                last_chk = fr_chk;
            end
        end else if (fr_addr == my_id && fr_type == TYPE_FILTER) begin
            if (fresh) fil_st = STAGE_RECEIVED;
        end
    endfunction

    function automatic void predict_replies(input t_item it);
        logic [7:0] x;
        x = it.rx_byte;
        case (it.mode)
            MODE_SETPOINT: begin
                pend_sp  = it.setpoint_half_deg;
                pend_cmd = CMD_SETPOINT;
            end
            MODE_TIME: begin
                if (it.clock_hour <= HOUR_MAX && it.clock_minute <= MINUTE_MAX) begin
                    pend_hr  = {3'b000, it.clock_hour};
                    pend_mn  = {2'b00, it.clock_minute};
                    pend_cmd = CMD_SETTIME;
                end
            end
            MODE_TOGGLE: begin
                if (it.toggle_select == SEL_LIGHT) pend_cmd = CMD_LIGHT;
                else if (it.toggle_select == SEL_JET1) pend_cmd = CMD_JET1;
                else if (it.toggle_select == SEL_JET2) pend_cmd = CMD_JET2;
            end
            default: begin
                if (fr_count == 8'd0) begin
                    if (x == FLAG) begin
                        fr_count = 8'd1;
                        fr_past = 1'b0;
                        fr_len = '0; fr_addr = '0; fr_type = '0;
                        fr_pay = '0; fr_hour = '0; fr_min = '0; fr_chk = '0;
                    end
                end else if (!(fr_count == 8'd1 && x == FLAG)) begin
                    if (!fr_past) capture_byte(fr_count, x);
                    if (fr_count < 8'd255) fr_count++;
                    else fr_past = 1'b1;
                    if (x == FLAG) begin
                        fr_count = 8'd0;
                        fr_past = 1'b0;
                        frame_done();
                    end
                end
            end
        endcase
    endfunction

    function automatic t_item rand_item(input t_mode m);
        logic [31:0] r;
        t_item       it;
        r = $urandom;
        it = r[$bits(t_item)-1:0];
        it.mode = m;
        return it;
    endfunction

    function automatic logic [7:0] nf_byte();
        logic [7:0] v;
        v = 8'($urandom);
        return (v == FLAG) ? 8'h7F : v;
    endfunction

    task automatic send_request(input t_item it);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        item_in <= it;
        do @(posedge i_clk); while (full);
        predict_replies(it);
        requests_sent++;
    endtask

    task automatic send_rx(input logic [7:0] x);
        t_item it;
        it = rand_item(MODE_RX);
        it.rx_byte = x;
        send_request(it);
    endtask

    task automatic send_setpoint(input logic [7:0] sp);
        t_item it;
        it = rand_item(MODE_SETPOINT);
        it.setpoint_half_deg = sp;
        send_request(it);
    endtask

    task automatic send_time(input logic [4:0] hr, input logic [5:0] mn);
        t_item it;
        it = rand_item(MODE_TIME);
        it.clock_hour = hr;
        it.clock_minute = mn;
        send_request(it);
    endtask

    task automatic send_toggle(input logic [1:0] sel);
        t_item it;
        it = rand_item(MODE_TOGGLE);
        it.toggle_select = sel;
        send_request(it);
    endtask

    // flag, length, address, tag, type, payload, check, flag; check sits at the length
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] kind, input int npay,
                              input logic [7:0] p5, input logic [7:0] p8,
                              input logic [7:0] p9, input logic [7:0] chk);
        int len;
        len = 5 + npay;
        send_rx(FLAG);
        if ($urandom_range(0, 3) == 0) send_rx(FLAG);
        send_rx(8'(len));
        send_rx(addr);
        send_rx(($urandom_range(0, 7) == 0) ? nf_byte() : CLIENT_TAG);
        send_rx(kind);
        for (int p = 5; p < len; p++) begin
            send_rx((p == 5) ? p5 : (p == 8) ? p8 : (p == 9) ? p9 : nf_byte());
        end
        send_rx(chk);
        send_rx(FLAG);
    endtask

    task automatic send_cts();
        send_frame(my_id, TYPE_CTS, $urandom_range(0, 2), nf_byte(), nf_byte(), nf_byte(),
                   nf_byte());
    endtask

    // hold off new requests until every pending reply byte has been popped
    task automatic wait_for_replies();
        @(negedge i_clk);
        push <= 1'b0;
        while (reply_bytes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_replies
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (reply_bytes_due.size() == 0) begin
                $error("unexpected reply byte: tx_byte=%h tx_last=%b",
                       result_out.tx_byte, result_out.tx_last);
                errors++;
            end else begin
                want = reply_bytes_due.pop_front();
                bytes_checked++;
                if (result_out.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, result_out.tx_byte);
                    errors++;
                end
                if (result_out.tx_last !== want.tx_last) begin
                    $error("tx_last: expected %b, got %b", want.tx_last, result_out.tx_last);
                    errors++;
                end
            end
        end
    end

    task automatic test_stray_bytes();
        send_rx(8'h00);
        send_rx(8'hFF);
    endtask

    task automatic test_short_frames();
        // doubled start flag, length 0: check position is the start flag
        send_rx(FLAG); send_rx(FLAG); send_rx(8'h00); send_rx(FLAG);
        // length 1: check position is the length byte
        send_rx(FLAG); send_rx(8'h01); send_rx(FLAG);
        // check position is the closing flag
        send_rx(FLAG); send_rx(8'h03); send_rx(ADDR_NEW); send_rx(FLAG);
    endtask

    task automatic test_registration();
        // id offer of zero: acked, node stays unregistered
        send_frame(ADDR_NEW, TYPE_ID_OFFER, 1, 8'h00, 8'h00, 8'h00, nf_byte());
        send_frame(ADDR_NEW, TYPE_POLL, 0, 8'h00, 8'h00, 8'h00, nf_byte());
        // id above the top gets clamped
        send_frame(ADDR_NEW, TYPE_ID_OFFER, 1, 8'hFF, 8'h00, 8'h00, nf_byte());
    endtask

    task automatic test_host_commands();
        send_time(5'd23, 6'd59);
        send_cts();
        send_setpoint(8'hFF);
        send_setpoint(8'h00);
        send_cts();
        send_toggle(SEL_LIGHT);
        send_toggle(SEL_JET1);
        send_toggle(SEL_JET2);
        send_toggle(2'd3);
        send_cts();
        // out-of-range times are dropped, so the request stage runs
        send_time(5'd24, 6'd0);
        send_time(5'd0, 6'd60);
        send_time(5'd31, 6'd63);
        send_cts();
    endtask

    task automatic test_long_frame();
        send_rx(FLAG);
        send_rx(8'hFF);
        send_rx(my_id);
        send_rx(CLIENT_TAG);
        send_rx(TYPE_CTS);
        // past position 255 the count saturates and nothing more is captured
        for (int p = 5; p < 264; p++) send_rx(nf_byte());
        send_rx(FLAG);
    endtask

    task automatic test_random_traffic(input int n_req, input int s_pct, input int r_pct);
        int         stop;
        int         pick;
        int         cnt;
        logic [7:0] kind;
        logic [7:0] chk;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop = requests_sent + n_req;
        while (requests_sent < stop) begin
            pick = $urandom_range(0, 99);
            chk  = ($urandom_range(0, 3) == 0) ? last_chk : nf_byte();
            if (chk == FLAG) chk = nf_byte();
            if (pick < 30) begin
                send_cts();
            end else if (pick < 40) begin
                send_frame(ADDR_BCAST, TYPE_STATUS, $urandom_range(3, 6), nf_byte(),
                           nf_byte(), nf_byte(), chk);
            end else if (pick < 50) begin
                cnt = $urandom_range(0, 2);
                kind = (cnt == 0) ? TYPE_CONFIG : (cnt == 1) ? TYPE_FAULT : TYPE_FILTER;
                send_frame(my_id, kind, $urandom_range(0, 3), nf_byte(), nf_byte(),
                           nf_byte(), chk);
            end else if (pick < 58) begin
                send_setpoint(8'($urandom));
            end else if (pick < 64) begin
                if ($urandom_range(0, 9) < 7)
                    send_time(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
                else
                    send_time(5'($urandom), 6'($urandom));
            end else if (pick < 70) begin
                send_toggle(2'($urandom));
            end else if (pick < 80) begin
                kind = nf_byte();
                send_frame(($urandom_range(0, 1) == 0) ? my_id : nf_byte(), kind,
                           $urandom_range(0, 6), nf_byte(), nf_byte(), nf_byte(), nf_byte());
            end else if (pick < 90) begin
                // broken frame with a random length byte and arbitrary size
                cnt = $urandom_range(1, 12);
                send_rx(FLAG);
                repeat (cnt) send_rx(nf_byte());
                send_rx(FLAG);
            end else begin
                send_rx(($urandom_range(0, 3) == 0) ? FLAG : 8'($urandom));
            end
        end
        wait_for_replies();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        item_in = '0;
        clear_client_state();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stray_bytes();
        test_short_frames();
        test_registration();
        test_host_commands();
        wait_for_replies();

        test_random_traffic(45, 35, 81);
        test_random_traffic(45, 81, 35);
        test_random_traffic(40, 0, 0);
        test_long_frame();

        @(negedge i_clk);
        push <= 1'b0;
        while (reply_bytes_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d requests (bus bytes and host commands), %0d reply frames, %0d bytes",
                 requests_sent, frames_due, bytes_checked);
        $display("under three idle patterns, short, broken and oversized frames included.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rbcr_pkg.sv
rtl/rbcr_front.sv
rtl/rbcr_fifo.sv
rtl/rbcr_back.sv
rtl/rs485_bus_client_responder_unit.sv
test/rs485_bus_client_responder_unit_tb.sv
